// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLI_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLI_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sli_pkg.sv -----
`timescale 1ns / 1ps

package sli_pkg;

	localparam int CAPACITY = 64;

	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_NOMATCH = 2'd1,
		STATUS_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

// ----- rtl/sli_if.sv -----
`timescale 1ns / 1ps

interface sli_req_if;
	logic                                valid;
	logic                                ready;
	logic                                cmd;
	logic signed [sli_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sli_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [sli_pkg::STATUS_W-1:0]        status;
	logic [sli_pkg::COUNT_W-1:0]         count;
	logic signed [sli_pkg::VALUE_W-1:0]  smallest;

	modport source (output valid, output status, output count, output smallest, input ready);
	modport sink   (input valid, input status, input count, input smallest, output ready);
endinterface

// ----- rtl/sorted_list_insert_delete.sv -----
`timescale 1ns / 1ps

// Sorted table of up to CAPACITY signed 32-bit values, kept in ascending order in a
// single-port-pair RAM. An insert (cmd 0) places the value ahead of the first stored
// value that is not smaller; a delete (cmd 1) removes the first equal value. Each
// request yields one response with status, count after the request and the smallest
// stored value (zero when empty). Requests are handled one at a time by a sequencer
// that walks the RAM with one shared comparator, one entry at a time (a read state,
// then an evaluate-and-write state, since the RAM read is registered). An insert
// into a full table or a delete from an empty one skips the scan and goes straight
// to the response state. The RAM needs no clearing after reset; entries at or
// above the count are never used.
module sorted_list_insert_delete #(
	parameter int CAPACITY = sli_pkg::CAPACITY
) (
	input  logic            clk,
	input  logic            arst_n,
	sli_req_if.sink         req,
	sli_rsp_if.source       rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int VW = sli_pkg::VALUE_W;

	sli_pkg::state_t       state_q, state_d;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         idx_q;
	logic                  cmd_q;
	logic signed [VW-1:0]  value_q;
	logic [VW-1:0]         carry_q;
	logic                  hit_q;
	sli_pkg::status_t      status_q;
	logic signed [VW-1:0]  smallest_q;

	logic                  rsp_valid_q;
	logic [sli_pkg::STATUS_W-1:0] rsp_status_q;
	logic [sli_pkg::COUNT_W-1:0]  rsp_count_q;
	logic signed [VW-1:0]  rsp_smallest_q;

	logic                  req_xfer;
	logic                  full;
	logic                  empty;
	logic                  early_done;
	logic                  last;
	logic                  place;
	logic                  hit_d;
	logic                  rsp_load;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [VW-1:0]         wr_data;
	logic [AW-1:0]         rd_addr;
	logic [VW-1:0]         rd_data;
	sli_pkg::cmp_res_t     cmp_res;

	sli_ram #(
		.WIDTH (VW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sli_cmp u_cmp (
		.a   ($signed(rd_data)),
		.b   (value_q),
		.res (cmp_res)
	);

	assign req_xfer   = req.valid && req.ready;
	assign full       = (fill_q >= CW'(CAPACITY));
	assign empty      = (fill_q == '0);
	assign early_done = (req.cmd == sli_pkg::CMD_INSERT) ? full : empty;
	assign rsp_load   = (state_q == sli_pkg::ST_FIN) && (!rsp_valid_q || rsp.ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sli_pkg::ST_IDLE: begin
				if (req_xfer) begin
					state_d = early_done ? sli_pkg::ST_FIN : sli_pkg::ST_READ;
				end
			end
			sli_pkg::ST_READ: begin
				state_d = sli_pkg::ST_EVAL;
			end
			sli_pkg::ST_EVAL: begin
				state_d = last ? sli_pkg::ST_FIN : sli_pkg::ST_READ;
			end
			sli_pkg::ST_FIN: begin
				if (rsp_load) begin
					state_d = sli_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sli_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs: handshake and RAM control.
	always_comb begin
		req.ready = 1'b0;
		rd_addr   = idx_q[AW-1:0];
		wr_en     = 1'b0;
		wr_addr   = idx_q[AW-1:0];
		wr_data   = carry_q;
		place     = 1'b0;
		last      = 1'b0;
		hit_d     = hit_q;
		case (state_q)
			sli_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			sli_pkg::ST_EVAL: begin
				if (cmd_q == sli_pkg::CMD_INSERT) begin
					// The new value goes ahead of the first entry that is not smaller;
					// every later entry moves up by one through the carry register.
					last  = (idx_q == fill_q);
					place = !hit_q && (last || !cmp_res.lt);
					hit_d = hit_q || place;
					if (place) begin
						wr_en   = 1'b1;
						wr_data = value_q;
					end else if (hit_q) begin
						wr_en   = 1'b1;
					end
				end else begin
					// Once the match is found, every later entry moves down by one.
					last  = ((idx_q + CW'(1)) == fill_q);
					hit_d = hit_q || cmp_res.eq;
					if (hit_q) begin
						wr_en   = 1'b1;
						wr_addr = AW'(idx_q - CW'(1));
						wr_data = rd_data;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sli_pkg::ST_IDLE;
			fill_q      <= '0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_xfer) begin
				hit_q <= 1'b0;
			end else if (state_q == sli_pkg::ST_EVAL) begin
				hit_q <= hit_d;
			end
			if ((state_q == sli_pkg::ST_EVAL) && last) begin
				if (cmd_q == sli_pkg::CMD_INSERT) begin
					fill_q <= fill_q + CW'(1);
				end else if (hit_d) begin
					fill_q <= fill_q - CW'(1);
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			cmd_q   <= req.cmd;
			value_q <= req.value;
			idx_q   <= '0;
			if (req.cmd == sli_pkg::CMD_INSERT) begin
				status_q <= sli_pkg::STATUS_FULL;
			end else begin
				status_q <= sli_pkg::STATUS_NOMATCH;
			end
		end
		if (state_q == sli_pkg::ST_EVAL) begin
			idx_q   <= idx_q + CW'(1);
			carry_q <= rd_data;
			if (last) begin
				if ((cmd_q == sli_pkg::CMD_INSERT) || hit_d) begin
					status_q <= sli_pkg::STATUS_OK;
				end else begin
					status_q <= sli_pkg::STATUS_NOMATCH;
				end
			end
		end
		// Shadow copy of the head entry, so the response needs no extra RAM read.
		if (wr_en && (wr_addr == '0)) begin
			smallest_q <= $signed(wr_data);
		end
		if (rsp_load) begin
			rsp_status_q   <= status_q;
			rsp_count_q    <= sli_pkg::COUNT_W'(fill_q);
			rsp_smallest_q <= empty ? '0 : smallest_q;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.count    = rsp_count_q;
	assign rsp.smallest = rsp_smallest_q;

`include "assert_macros.svh"

	`SLI_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CW'(CAPACITY), "fill exceeds capacity")
	`SLI_ASSERT_IMPL(a_write_in_range, wr_en, idx_q <= fill_q, "RAM write beyond the stored range")
	`SLI_ASSERT_NEXT(a_fill_step, state_q != sli_pkg::ST_EVAL, $stable(fill_q), "fill changed outside an evaluate step")

endmodule

// ----- rtl/sli_ram.sv -----
`timescale 1ns / 1ps

module sli_ram #(
	parameter int WIDTH = sli_pkg::VALUE_W,
	parameter int DEPTH = sli_pkg::CAPACITY
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/sli_cmp.sv -----
`timescale 1ns / 1ps

// Shared comparator: every scan step of the sequencer goes through this unit.
module sli_cmp (
	input  logic signed [sli_pkg::VALUE_W-1:0] a,
	input  logic signed [sli_pkg::VALUE_W-1:0] b,
	output sli_pkg::cmp_res_t                  res
);

	assign res.lt = (a < b);
	assign res.eq = (a == b);

endmodule
